[rtl/lfps_pkg.sv]
// Shared types and constants for the line follower PD steering core.
// No dependencies; every other file in rtl/ depends on this package.
package lfps_pkg;

  localparam int POS_W   = 13;
  localparam int GAIN_W  = 12;
  localparam int SPEED_W = 14;
  localparam int EDGE_W  = 10;
  localparam int TYPE_W  = 3;
  localparam int ERR_W   = 14;
  localparam int DIFF_W  = 15;
  localparam int PP_W    = 27;
  localparam int PD_W    = 28;
  localparam int SUM_W   = 29;
  localparam int ADJ_W   = SUM_W - 8;
  localparam int VAL_W   = 23;
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 14;
  localparam int IDX_W   = 3;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [TYPE_W-1:0] REQ_SAMPLE  = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_RAMP    = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_CONFIRM = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_RISE    = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_FALL    = 3'd4;

  localparam logic [POS_W-1:0]  CENTER_LO  = 13'd3200;
  localparam logic [POS_W-1:0]  CENTER_HI  = 13'd3800;
  localparam logic [EDGE_W-1:0] EDGE_DARK  = 10'd400;
  localparam logic [CNT_W-1:0]  CNT_MAX    = 16'hFFFF;

  localparam logic [POS_W-1:0]   RST_SETPOINT = 13'd3500;
  localparam logic [GAIN_W-1:0]  RST_KP       = 12'd51;
  localparam logic [GAIN_W-1:0]  RST_KD       = 12'd256;
  localparam logic [SPEED_W-1:0] RST_MAX      = 14'd10000;
  localparam logic [SPEED_W-1:0] RST_MIN      = 14'd0;
  localparam logic [SPEED_W-1:0] RST_START    = 14'd4000;
  localparam logic [SPEED_W-1:0] RST_CRUISE   = 14'd8000;
  localparam logic [SPEED_W-1:0] RST_STEP     = 14'd1000;

  typedef enum logic [IDX_W-1:0] {
    CFG_SETPOINT = 3'd0,
    CFG_KP       = 3'd1,
    CFG_KD       = 3'd2,
    CFG_MAX      = 3'd3,
    CFG_MIN      = 3'd4,
    CFG_START    = 3'd5,
    CFG_CRUISE   = 3'd6,
    CFG_STEP     = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    K_SAMPLE,
    K_RAMP,
    K_CONFIRM,
    K_RISE,
    K_FALL,
    K_IGNORE
  } req_kind_t;

  typedef struct packed {
    logic [POS_W-1:0]   line_setpoint;
    logic [GAIN_W-1:0]  prop_gain_q8;
    logic [GAIN_W-1:0]  deriv_gain_q8;
    logic [SPEED_W-1:0] speed_ceiling;
    logic [SPEED_W-1:0] speed_floor;
    logic [SPEED_W-1:0] start_speed;
    logic [SPEED_W-1:0] cruise_speed;
    logic [SPEED_W-1:0] ramp_step;
  } cfg_t;

  typedef struct packed {
    req_kind_t          kind;
    logic [POS_W-1:0]   line_pos;
    logic [EDGE_W-1:0]  left_edge;
    logic [EDGE_W-1:0]  right_edge;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  function automatic logic [SPEED_W-1:0] clamp_speed(
    input logic signed [VAL_W-1:0] v,
    input logic [SPEED_W-1:0]      hi,
    input logic [SPEED_W-1:0]      lo
  );
    logic signed [VAL_W-1:0] hi_ext;
    logic signed [VAL_W-1:0] lo_ext;
    hi_ext = $signed({{(VAL_W-SPEED_W){1'b0}}, hi});
    lo_ext = $signed({{(VAL_W-SPEED_W){1'b0}}, lo});
    if (v >= hi_ext) begin
      return hi;
    end else if (v <= lo_ext) begin
      return lo;
    end else begin
      return v[SPEED_W-1:0];
    end
  endfunction

endpackage

[rtl/lfps_req_if.sv]
// Request channel: valid/ready plus one input item.
// Depends on lfps_pkg for field widths.
interface lfps_req_if;
  logic                         valid;
  logic                         ready;
  logic [lfps_pkg::TYPE_W-1:0]  req_type;
  logic [lfps_pkg::POS_W-1:0]   line_pos;
  logic [lfps_pkg::EDGE_W-1:0]  left_edge_level;
  logic [lfps_pkg::EDGE_W-1:0]  right_edge_level;

  modport source (output valid, req_type, line_pos, left_edge_level, right_edge_level,
                  input ready);
  modport sink   (input valid, req_type, line_pos, left_edge_level, right_edge_level,
                  output ready);
endinterface

[rtl/lfps_res_if.sv]
// Result channel: valid/ready plus wheel speeds and running flag.
// Depends on lfps_pkg for field widths.
interface lfps_res_if;
  logic                          valid;
  logic                          ready;
  logic [lfps_pkg::SPEED_W-1:0]  left_speed;
  logic [lfps_pkg::SPEED_W-1:0]  right_speed;
  logic                          running;

  modport source (output valid, left_speed, right_speed, running, input ready);
  modport sink   (input valid, left_speed, right_speed, running, output ready);
endinterface

[rtl/lfps_cfg.sv]
// Configuration register file, written through a plain write port.
// Depends on lfps_pkg.
module lfps_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lfps_pkg::IDX_W-1:0]  cfg_index,
  input  logic [lfps_pkg::CFG_W-1:0]  cfg_data,
  output lfps_pkg::cfg_t              cfg
);
  import lfps_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_setpoint <= RST_SETPOINT;
      cfg.prop_gain_q8  <= RST_KP;
      cfg.deriv_gain_q8 <= RST_KD;
      cfg.speed_ceiling <= RST_MAX;
      cfg.speed_floor   <= RST_MIN;
      cfg.start_speed   <= RST_START;
      cfg.cruise_speed  <= RST_CRUISE;
      cfg.ramp_step     <= RST_STEP;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SETPOINT: cfg.line_setpoint <= cfg_data[POS_W-1:0];
        CFG_KP:       cfg.prop_gain_q8  <= cfg_data[GAIN_W-1:0];
        CFG_KD:       cfg.deriv_gain_q8 <= cfg_data[GAIN_W-1:0];
        CFG_MAX:      cfg.speed_ceiling <= cfg_data[SPEED_W-1:0];
        CFG_MIN:      cfg.speed_floor   <= cfg_data[SPEED_W-1:0];
        CFG_START:    cfg.start_speed   <= cfg_data[SPEED_W-1:0];
        CFG_CRUISE:   cfg.cruise_speed  <= cfg_data[SPEED_W-1:0];
        CFG_STEP:     cfg.ramp_step     <= cfg_data[SPEED_W-1:0];
      endcase
    end
  end

endmodule

[rtl/lfps_front.sv]
// Front end: accepts requests, decodes the request type and queues them.
// Depends on lfps_pkg and lfps_req_if.
module lfps_front (
  input  logic            clk,
  input  logic            rst,
  lfps_req_if.sink        req,
  input  logic            pop,
  output lfps_pkg::head_t head
);
  import lfps_pkg::*;

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QDEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QDEPTH);

  item_t             q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  item_t             decoded;
  logic              push;
  logic              do_pop;

  always_comb begin
    decoded.line_pos   = req.line_pos;
    decoded.left_edge  = req.left_edge_level;
    decoded.right_edge = req.right_edge_level;
    unique case (req.req_type)
      REQ_SAMPLE:  decoded.kind = K_SAMPLE;
      REQ_RAMP:    decoded.kind = K_RAMP;
      REQ_CONFIRM: decoded.kind = K_CONFIRM;
      REQ_RISE:    decoded.kind = K_RISE;
      REQ_FALL:    decoded.kind = K_FALL;
      default:     decoded.kind = K_IGNORE;
    endcase
  end

  assign req.ready  = (count != CNT_FULL);
  assign push       = req.valid && req.ready;
  assign do_pop     = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/lfps_back.sv]
// Back end: executes queued requests (state update and PD products), then
// forms clamped wheel speeds into the result register. Depends on lfps_pkg, lfps_res_if.
module lfps_back (
  input  logic            clk,
  input  logic            rst,
  input  lfps_pkg::cfg_t  cfg,
  input  lfps_pkg::head_t head,
  output logic            pop,
  lfps_res_if.source      res
);
  import lfps_pkg::*;

  // architectural state
  logic signed [ERR_W-1:0] previous_error, previous_error_next;
  logic [SPEED_W-1:0]      base_speed, base_speed_next;
  logic                    ramping, ramping_next;
  logic [POS_W-1:0]        saved_line_pos, saved_line_pos_next;
  logic [EDGE_W-1:0]       saved_left_edge, saved_left_edge_next;
  logic [EDGE_W-1:0]       saved_right_edge, saved_right_edge_next;
  logic                    sample_seen, sample_seen_next;
  logic                    fall_seen, fall_seen_next;
  logic                    armed, armed_next;
  logic [CNT_W-1:0]        test_count, test_count_next;
  logic [CNT_W-1:0]        confirm_count, confirm_count_next;
  logic                    run_flag, run_flag_next;

  // execute -> speed stage
  logic                    p_valid;
  logic                    p_sample, p_sample_next;
  logic                    p_stop, p_stop_next;
  logic                    p_run;
  logic [SPEED_W-1:0]      p_base;
  logic signed [PP_W-1:0]  p_prod_p;
  logic signed [PD_W-1:0]  p_prod_d;

  logic [SPEED_W-1:0]      left_reg, right_reg;
  logic                    run_out;
  logic                    out_valid;

  logic                    advance;
  logic                    go;
  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PP_W-1:0]   prod_p;
  logic signed [PD_W-1:0]   prod_d;
  logic [SPEED_W:0]         ramp_sum;
  logic [CNT_W+3:0]         conf_x10;
  logic [CNT_W+3:0]         test_x9;
  logic                     centered;

  logic signed [SUM_W-1:0]  pd_sum;
  logic signed [ADJ_W-1:0]  adj;
  logic signed [VAL_W-1:0]  base_ext, adj_ext, v_left, v_right;

  assign advance = !out_valid || res.ready;
  assign go      = advance && head.valid;
  assign pop     = go;

  // execute stage
  assign err  = $signed({1'b0, cfg.line_setpoint}) - $signed({1'b0, head.item.line_pos});
  assign diff = $signed({err[ERR_W-1], err})
              - $signed({previous_error[ERR_W-1], previous_error});
  assign prod_p = $signed({1'b0, cfg.prop_gain_q8}) * err;
  assign prod_d = $signed({1'b0, cfg.deriv_gain_q8}) * diff;

  assign ramp_sum = {1'b0, base_speed} + {1'b0, cfg.ramp_step};
  assign conf_x10 = ({4'b0, confirm_count} << 3) + ({4'b0, confirm_count} << 1);
  assign test_x9  = ({4'b0, test_count} << 3) + {4'b0, test_count};
  assign centered = (saved_line_pos > CENTER_LO) && (saved_line_pos < CENTER_HI)
                 && (saved_left_edge < EDGE_DARK) && (saved_right_edge < EDGE_DARK);

  always_comb begin
    previous_error_next   = previous_error;
    base_speed_next       = base_speed;
    ramping_next          = ramping;
    saved_line_pos_next   = saved_line_pos;
    saved_left_edge_next  = saved_left_edge;
    saved_right_edge_next = saved_right_edge;
    sample_seen_next      = sample_seen;
    fall_seen_next        = fall_seen;
    armed_next            = armed;
    test_count_next       = test_count;
    confirm_count_next    = confirm_count;
    run_flag_next         = run_flag;
    p_sample_next         = 1'b0;
    p_stop_next           = 1'b0;
    if (run_flag) begin
      unique case (head.item.kind)
        K_SAMPLE: begin
          saved_line_pos_next   = head.item.line_pos;
          saved_left_edge_next  = head.item.left_edge;
          saved_right_edge_next = head.item.right_edge;
          sample_seen_next      = 1'b1;
          previous_error_next   = err;
          p_sample_next         = 1'b1;
        end
        K_RAMP: begin
          if (ramping) begin
            if (ramp_sum >= {1'b0, cfg.cruise_speed}) begin
              base_speed_next = cfg.cruise_speed;
              ramping_next    = 1'b0;
            end else begin
              base_speed_next = ramp_sum[SPEED_W-1:0];
            end
          end
        end
        K_CONFIRM: begin
          if (armed && sample_seen && (test_count != CNT_MAX)) begin
            if (centered) begin
              confirm_count_next = confirm_count + 1'b1;
            end
            test_count_next = test_count + 1'b1;
          end
        end
        K_RISE: begin
          if (fall_seen && (test_count == '0)) begin
            armed_next = 1'b1;
          end
        end
        K_FALL: begin
          if (fall_seen) begin
            armed_next = 1'b0;
            if ((test_count != '0) && (conf_x10 > test_x9)) begin
              run_flag_next = 1'b0;
              p_stop_next   = 1'b1;
            end
            test_count_next    = '0;
            confirm_count_next = '0;
          end
          fall_seen_next = 1'b1;
        end
        K_IGNORE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error   <= '0;
      base_speed       <= RST_START;
      ramping          <= 1'b1;
      saved_line_pos   <= '0;
      saved_left_edge  <= '0;
      saved_right_edge <= '0;
      sample_seen      <= 1'b0;
      fall_seen        <= 1'b0;
      armed            <= 1'b0;
      test_count       <= '0;
      confirm_count    <= '0;
      run_flag         <= 1'b1;
      p_valid          <= 1'b0;
      p_sample         <= 1'b0;
      p_stop           <= 1'b0;
    end else if (advance) begin
      p_valid  <= head.valid;
      p_sample <= go && p_sample_next;
      p_stop   <= go && p_stop_next;
      if (go) begin
        previous_error   <= previous_error_next;
        base_speed       <= base_speed_next;
        ramping          <= ramping_next;
        saved_line_pos   <= saved_line_pos_next;
        saved_left_edge  <= saved_left_edge_next;
        saved_right_edge <= saved_right_edge_next;
        sample_seen      <= sample_seen_next;
        fall_seen        <= fall_seen_next;
        armed            <= armed_next;
        test_count       <= test_count_next;
        confirm_count    <= confirm_count_next;
        run_flag         <= run_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      p_run    <= run_flag_next;
      p_base   <= base_speed_next;
      p_prod_p <= prod_p;
      p_prod_d <= prod_d;
    end
  end

  // speed stage: floor(sum / 256) is the upper bits of the sum
  assign pd_sum   = $signed({{(SUM_W-PP_W){p_prod_p[PP_W-1]}}, p_prod_p})
                  + $signed({{(SUM_W-PD_W){p_prod_d[PD_W-1]}}, p_prod_d});
  assign adj      = pd_sum[SUM_W-1:8];
  assign base_ext = $signed({{(VAL_W-SPEED_W){1'b0}}, p_base});
  assign adj_ext  = $signed({{(VAL_W-ADJ_W){adj[ADJ_W-1]}}, adj});
  assign v_left   = base_ext - adj_ext;
  assign v_right  = base_ext + adj_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      left_reg  <= '0;
      right_reg <= '0;
      run_out   <= 1'b1;
    end else if (advance) begin
      out_valid <= p_valid;
      if (p_valid) begin
        run_out <= p_run;
        if (p_stop) begin
          left_reg  <= '0;
          right_reg <= '0;
        end else if (p_sample) begin
          left_reg  <= clamp_speed(v_left, cfg.speed_ceiling, cfg.speed_floor);
          right_reg <= clamp_speed(v_right, cfg.speed_ceiling, cfg.speed_floor);
        end
      end
    end
  end

  assign res.valid       = out_valid;
  assign res.left_speed  = left_reg;
  assign res.right_speed = right_reg;
  assign res.running     = run_out;

endmodule

[rtl/line_follow_pd_steering_lap_stop_core.sv]
// Top level of the line follower PD steering core with soft start and lap stop.
// Depends on lfps_pkg, lfps_req_if, lfps_res_if, lfps_cfg, lfps_front, lfps_back.
//
// Usage:
//   req carries one request per transfer: a line sample, a soft-start tick, a
//   confirm tick, or a marker rise or fall. Every request gives exactly one
//   transfer on res: the current left and right wheel speeds and the running
//   flag. Results come back in request order.
//   Registers are written through cfg_we / cfg_index / cfg_data while no
//   request is in flight; they take effect for the next request.
//   An accepted request passes through the decode queue, the execute stage
//   and the speed stage before its result shows on res.
//   Throughput: one request per cycle while res is ready; the execute stage
//   holds both PD multiplies, the speed stage the add, shift and clamp.
//   When res is stalled the result register holds; a two-entry queue
//   between front and back keeps req ready until it fills.
//   Reset (rst, synchronous) loads register defaults, sets base speed to the
//   default start speed, clears counters and empties the pipeline.
//   After an end-of-lap stop every result reads zero speeds, running low.
module line_follow_pd_steering_lap_stop_core (
  input  logic                        clk,
  input  logic                        rst,
  lfps_req_if.sink                    req,
  lfps_res_if.source                  res,
  input  logic                        cfg_we,
  input  logic [lfps_pkg::IDX_W-1:0]  cfg_index,
  input  logic [lfps_pkg::CFG_W-1:0]  cfg_data
);
  import lfps_pkg::*;

  cfg_t  cfg;
  head_t head;
  logic  pop;

  lfps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lfps_front u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .pop  (pop),
    .head (head)
  );

  lfps_back u_back (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .head (head),
    .pop  (pop),
    .res  (res)
  );

endmodule

[bench/tb.sv]
// Self-checking bench for line_follow_pd_steering_lap_stop_core: PD steering, soft-start
// ramp, lap confirm counting and end-of-lap stop, checked against an in-bench model.
// Depends on lfps_pkg, lfps_req_if, lfps_res_if and the core itself.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lfps_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [TYPE_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [EDGE_W-1:0] le;
    logic [EDGE_W-1:0] re;
  } req_t;

  typedef struct packed {
    logic [SPEED_W-1:0] left;
    logic [SPEED_W-1:0] right;
    logic               running;
  } wheel_t;

  typedef struct packed {
    logic [ERR_W-1:0]   prev_err;
    logic [SPEED_W-1:0] base;
    logic               ramping;
    logic [POS_W-1:0]   pos;
    logic [EDGE_W-1:0]  le, re;
    logic               seen, fell, armed;
    logic [CNT_W-1:0]   tests, confirms;
    logic               run;
    logic [SPEED_W-1:0] left, right;
  } steer_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  lfps_req_if req_bus();
  lfps_res_if res_bus();

  line_follow_pd_steering_lap_stop_core dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .res(res_bus),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  cfg_t   regs;
  steer_t live_state;
  steer_t plan_state;
  req_t   req_backlog[$];
  wheel_t speed_expect[$];
  bit     calm;
  bit     stop_ok;
  bit     req_taken;
  bit     res_taken;
  int     errors;
  int     n_posted;
  int     n_sent;
  int     n_checked;
  int     n_settings;
  int     stall_cycles;

  function automatic logic [SPEED_W-1:0] wheel_limit(input longint v, input cfg_t c);
    if (v >= longint'(c.speed_ceiling)) return c.speed_ceiling;
    if (v <= longint'(c.speed_floor)) return c.speed_floor;
    return v[SPEED_W-1:0];
  endfunction

  function automatic wheel_t steer_step(input steer_t s_in, input cfg_t c, input req_t r,
                                        output steer_t s_out);
    steer_t s;
    longint err_v;
    longint sum_v;
    longint adj_v;
    longint nb;
    s = s_in;
    if (s.run) begin
      case (r.kind)
        REQ_SAMPLE: begin
          s.pos = r.pos;
          s.le = r.le;
          s.re = r.re;
          s.seen = 1'b1;
          err_v = longint'(c.line_setpoint) - longint'(r.pos);
          sum_v = longint'(c.prop_gain_q8) * err_v
                + longint'(c.deriv_gain_q8) * (err_v - longint'($signed(s.prev_err)));
          adj_v = sum_v >>> 8;
          s.left = wheel_limit(longint'(s.base) - adj_v, c);
          s.right = wheel_limit(longint'(s.base) + adj_v, c);
          s.prev_err = err_v[ERR_W-1:0];
        end
        REQ_RAMP: begin
          if (s.ramping) begin
            nb = longint'(s.base) + longint'(c.ramp_step);
            if (nb >= longint'(c.cruise_speed)) begin
              s.base = c.cruise_speed;
              s.ramping = 1'b0;
            end else begin
              s.base = nb[SPEED_W-1:0];
            end
          end
        end
        REQ_CONFIRM: begin
          if (s.armed && s.seen && s.tests != CNT_MAX) begin
            if (s.pos > CENTER_LO && s.pos < CENTER_HI && s.le < EDGE_DARK
                && s.re < EDGE_DARK) begin
              s.confirms = s.confirms + 1'b1;
            end
            s.tests = s.tests + 1'b1;
          end
        end
        REQ_RISE: begin
          if (s.fell && s.tests == '0) s.armed = 1'b1;
        end
        REQ_FALL: begin
          if (s.fell) begin
            s.armed = 1'b0;
            if (s.tests != '0 && longint'(s.confirms) * 10 > longint'(s.tests) * 9) begin
              s.run = 1'b0;
              s.left = '0;
              s.right = '0;
            end
            s.tests = '0;
            s.confirms = '0;
          end
          s.fell = 1'b1;
        end
        default: ;
      endcase
    end
    s_out = s;
    return {s.left, s.right, s.run};
  endfunction

  function automatic req_t mk(input logic [TYPE_W-1:0] k);
    req_t r;
    r.kind = k;
    r.pos = ($urandom_range(9) == 0) ? POS_W'($urandom_range(8191))
                                     : POS_W'($urandom_range(7000));
    r.le = EDGE_W'($urandom_range(1023));
    r.re = EDGE_W'($urandom_range(1023));
    return r;
  endfunction

  function automatic req_t sample_of(input bit good);
    req_t r;
    r = mk(REQ_SAMPLE);
    if (good) begin
      r.pos = POS_W'($urandom_range(3799, 3201));
      r.le = EDGE_W'($urandom_range(399));
      r.re = EDGE_W'($urandom_range(399));
    end
    return r;
  endfunction

  function automatic req_t fixed(input logic [TYPE_W-1:0] k, input int p, input int l,
                                 input int rr);
    req_t r;
    r.kind = k;
    r.pos = POS_W'(p);
    r.le = EDGE_W'(l);
    r.re = EDGE_W'(rr);
    return r;
  endfunction

  // A fall that would end the run is dropped until the closing lap.
  task automatic post(input req_t r);
    steer_t trial;
    wheel_t w;
    w = steer_step(plan_state, regs, r, trial);
    if (!w.running && plan_state.run && !stop_ok) return;
    plan_state = trial;
    req_backlog.push_back(r);
    if (r.kind <= REQ_FALL) n_posted++;
  endtask

  task automatic post_lap();
    int n;
    int q;
    n = $urandom_range(25, 1);
    q = $urandom_range(100);
    if ($urandom_range(9) == 0) post(mk(REQ_FALL));
    post(mk(REQ_RISE));
    post(sample_of($urandom_range(99) < q));
    repeat (n) begin
      if ($urandom_range(2) == 0) post(sample_of($urandom_range(99) < q));
      post(mk(REQ_CONFIRM));
    end
    post(mk(REQ_FALL));
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SETPOINT: regs.line_setpoint = val[POS_W-1:0];
      CFG_KP:       regs.prop_gain_q8 = val[GAIN_W-1:0];
      CFG_KD:       regs.deriv_gain_q8 = val[GAIN_W-1:0];
      CFG_MAX:      regs.speed_ceiling = val;
      CFG_MIN:      regs.speed_floor = val;
      CFG_START:    regs.start_speed = val;
      CFG_CRUISE:   regs.cruise_speed = val;
      CFG_STEP:     regs.ramp_step = val;
      default: ;
    endcase
  endtask

  task automatic set_all(input int sp, input int kp, input int kd, input int mx, input int mn,
                         input int st, input int cr, input int rs);
    write_reg(CFG_SETPOINT, CFG_W'(sp));
    write_reg(CFG_KP, CFG_W'(kp));
    write_reg(CFG_KD, CFG_W'(kd));
    write_reg(CFG_MAX, CFG_W'(mx));
    write_reg(CFG_MIN, CFG_W'(mn));
    write_reg(CFG_START, CFG_W'(st));
    write_reg(CFG_CRUISE, CFG_W'(cr));
    write_reg(CFG_STEP, CFG_W'(rs));
    n_settings++;
  endtask

  task automatic settle();
    while (req_backlog.size() != 0 || speed_expect.size() != 0 || req_bus.valid)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_taken) begin
      if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= 7)) begin
        req_bus.valid <= 1'b1;
        req_bus.req_type <= req_backlog[0].kind;
        req_bus.line_pos <= req_backlog[0].pos;
        req_bus.left_edge_level <= req_backlog[0].le;
        req_bus.right_edge_level <= req_backlog[0].re;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
    res_bus.ready <= calm || ($urandom_range(99) >= 7);
  end

  // monitor, model update and watchdog
  always @(posedge clk) begin : check_side
    req_t   r;
    wheel_t w;
    wheel_t got;
    steer_t nxt;
    req_taken = 1'b0;
    res_taken = 1'b0;
    if (!rst) begin
      if (req_bus.valid && req_bus.ready) begin
        req_taken = 1'b1;
        r = {req_bus.req_type, req_bus.line_pos, req_bus.left_edge_level,
             req_bus.right_edge_level};
        w = steer_step(live_state, regs, r, nxt);
        live_state = nxt;
        speed_expect.push_back(w);
        void'(req_backlog.pop_front());
        n_sent++;
      end
      if (res_bus.valid && res_bus.ready) begin
        res_taken = 1'b1;
        got = {res_bus.left_speed, res_bus.right_speed, res_bus.running};
        if (speed_expect.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          w = speed_expect.pop_front();
          n_checked++;
          if (got.left !== w.left) begin
            $error("left_speed: expected %0d, got %0d", w.left, got.left);
            errors++;
          end
          if (got.right !== w.right) begin
            $error("right_speed: expected %0d, got %0d", w.right, got.right);
            errors++;
          end
          if (got.running !== w.running) begin
            $error("running: expected %0b, got %0b", w.running, got.running);
            errors++;
          end
        end
      end
      if (req_taken || res_taken) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("watchdog: %0d cycles without a transfer", STALL_LIMIT);
          $display("[line_follow_pd_steering_lap_stop_core] ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    int target;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_SETPOINT;
    cfg_data = '0;
    req_bus.valid = 1'b0;
    req_bus.req_type = REQ_SAMPLE;
    req_bus.line_pos = '0;
    req_bus.left_edge_level = '0;
    req_bus.right_edge_level = '0;
    res_bus.ready = 1'b0;
    calm = 1'b0;
    stop_ok = 1'b0;
    errors = 0;
    n_posted = 0;
    n_sent = 0;
    n_checked = 0;
    n_settings = 1;
    stall_cycles = 0;
    regs.line_setpoint = RST_SETPOINT;
    regs.prop_gain_q8 = RST_KP;
    regs.deriv_gain_q8 = RST_KD;
    regs.speed_ceiling = RST_MAX;
    regs.speed_floor = RST_MIN;
    regs.start_speed = RST_START;
    regs.cruise_speed = RST_CRUISE;
    regs.ramp_step = RST_STEP;
    live_state = '0;
    live_state.base = RST_START;
    live_state.ramping = 1'b1;
    live_state.run = 1'b1;
    plan_state = live_state;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: position extremes, ramp, unknown types, arming, 9-of-10 lap
    post(fixed(REQ_SAMPLE, 3500, 0, 0));
    post(fixed(REQ_SAMPLE, 0, 1023, 1023));
    post(fixed(REQ_SAMPLE, 7000, 1000, 0));
    post(fixed(REQ_SAMPLE, 8191, 0, 1000));
    post(fixed(REQ_RAMP, 0, 0, 0));
    post(fixed(REQ_RAMP, 8191, 1023, 1023));
    post(mk(3'd5));
    post(mk(3'd6));
    post(mk(3'd7));
    post(fixed(REQ_CONFIRM, 3500, 0, 0));
    post(fixed(REQ_RISE, 0, 0, 0));
    post(fixed(REQ_FALL, 0, 0, 0));
    post(fixed(REQ_RISE, 0, 0, 0));
    post(fixed(REQ_SAMPLE, 3200, 0, 0));
    post(fixed(REQ_CONFIRM, 0, 0, 0));
    post(fixed(REQ_SAMPLE, 3500, 399, 399));
    repeat (9) post(fixed(REQ_CONFIRM, 0, 0, 0));
    post(fixed(REQ_FALL, 0, 0, 0));
    post(fixed(REQ_SAMPLE, 3799, 400, 0));
    post(fixed(REQ_SAMPLE, 3801, 0, 400));
    settle();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: set_all(0, 4095, 4095, 16383, 0, 16383, 16383, 0);
        1: set_all(8191, 0, 0, 0, 16383, 0, 0, 0);
        3: set_all(3500, 51, 256, 10000, 0, 4000, 9000, 700);
        5: set_all(3500, 2048, 4095, 5000, 6000, 100, 10000, 16383);
        default: set_all($urandom_range(8191), $urandom_range(4095), $urandom_range(4095),
                         $urandom_range(10000, 2000), $urandom_range(1500),
                         $urandom_range(10000), $urandom_range(10000),
                         $urandom_range(2000));
      endcase
      calm = (p == 4);
      repeat (6) post(mk(REQ_RAMP));
      target = n_posted + 92;
      while (n_posted < target) begin
        if ($urandom_range(99) < 60) begin
          post_lap();
        end else begin
          repeat ($urandom_range(5, 1)) post(mk(TYPE_W'($urandom_range(7))));
        end
      end
      settle();
      calm = 1'b0;
    end

    // closing lap ends in a stop, then the stopped core is exercised
    stop_ok = 1'b1;
    post(mk(REQ_FALL));
    post(mk(REQ_RISE));
    post(fixed(REQ_SAMPLE, 3500, 0, 0));
    repeat (6) post(mk(REQ_CONFIRM));
    post(mk(REQ_FALL));
    repeat (12) post(mk(TYPE_W'($urandom_range(7))));
    settle();
    repeat (8) @(negedge clk);

    $display("%0d requests driven, %0d results checked over %0d register settings",
             n_sent, n_checked, n_settings);
    $display("ramp, lap confirm and stop paths covered; core stopped at end: %0b",
             !live_state.run);
    if (errors == 0) begin
      $display("[line_follow_pd_steering_lap_stop_core] OK");
    end else begin
      $display("[line_follow_pd_steering_lap_stop_core] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/lfps_pkg.sv
rtl/lfps_req_if.sv
rtl/lfps_res_if.sv
rtl/lfps_cfg.sv
rtl/lfps_front.sv
rtl/lfps_back.sv
rtl/line_follow_pd_steering_lap_stop_core.sv
bench/tb.sv
